/* sv/cbg_pkg.sv */
// Shared types and constants for the Chimera cell bond generator.
// Depends on nothing; every other file imports it.
package cbg_pkg;

    // Design limits
    localparam int MAX_GRID  = 16;
    localparam int MAX_SHORE = 7;

    // Field widths fixed by the interface
    localparam int COORD_W    = 4;
    localparam int GRID_W     = 5;
    localparam int SHORE_W    = 3;
    localparam int SITE_W     = 12;
    localparam int COUPLING_W = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    // cols * row + col
    localparam int CELL_IDX_W = GRID_W + COORD_W;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS     = 4'd0,
        CFG_GRID_ROWS     = 4'd1,
        CFG_SHORE_SIZE    = 4'd2,
        CFG_COUPLING_BITS = 4'd3
    } cfg_index_t;

    // Input beat
    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } cbg_in_t;

    // Output beat
    typedef struct packed {
        logic [SITE_W-1:0]     site_a;
        logic [SITE_W-1:0]     site_b;
        logic [COUPLING_W-1:0] coupling;
        logic                  last;
        logic                  bad_cell;
    } cbg_out_t;

    // Configuration register file
    typedef struct packed {
        logic [GRID_W-1:0]     grid_cols;
        logic [GRID_W-1:0]     grid_rows;
        logic [SHORE_W-1:0]    shore_size;
        logic [COUPLING_W-1:0] coupling_bits;
    } cbg_cfg_t;

    // Classified cell handed from front to back
    typedef struct packed {
        logic               bad;          // cell outside grid
        logic [SITE_W-1:0]  base;         // first spin of the cell
        logic [SHORE_W-1:0] shore;        // saturated shore size, nonzero unless bad
        logic               has_down;     // cell below exists
        logic               has_right;    // cell to the right exists
        logic [SITE_W-1:0]  stride_down;  // spins per grid row of cells
    } cbg_cmd_t;

    // Back sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_BAD,
        BK_INNER,
        BK_DOWN,
        BK_RIGHT
    } bk_state_t;

endpackage

/* sv/cbg_front.sv */
// Front end: accepts cells, checks them against the grid and builds commands.
// Depends on cbg_pkg; feeds cbg_queue.
module cbg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  cbg_pkg::cbg_cfg_t cfg,
    input  logic              cell_valid,
    output logic              cell_ready,
    input  cbg_pkg::cbg_in_t  coord,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cbg_pkg::cbg_cmd_t cmd
);
    import cbg_pkg::*;

    logic [GRID_W-1:0]     cols_sat;
    logic [GRID_W-1:0]     rows_sat;
    logic [SHORE_W-1:0]    shore_sat;
    logic [SHORE_W:0]      two_s;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_bad_reg;
    logic                  s1_down_reg;
    logic                  s1_right_reg;
    logic [CELL_IDX_W-1:0] s1_idx_reg;

    logic                  bad_now;
    logic                  push_needed;
    logic                  s1_done;
    logic                  accept;

    // Saturate configuration to the design limits
    always_comb
    begin
        cols_sat  = (32'(cfg.grid_cols) > MAX_GRID) ? GRID_W'(MAX_GRID) : cfg.grid_cols;
        rows_sat  = (32'(cfg.grid_rows) > MAX_GRID) ? GRID_W'(MAX_GRID) : cfg.grid_rows;
        shore_sat = (32'(cfg.shore_size) > MAX_SHORE) ? SHORE_W'(MAX_SHORE)
                                                      : cfg.shore_size;
        two_s     = {shore_sat, 1'b0};
    end

    // Stage 1 classification on the incoming cell
    assign bad_now = ({1'b0, coord.cell_row} >= rows_sat) ||
                     ({1'b0, coord.cell_col} >= cols_sat);

    // A zero-shore cell inside the grid yields nothing and is dropped here
    assign push_needed = s1_bad_reg || (shore_sat != '0);
    assign s1_done     = s1_valid_reg && (!push_needed || cmd_ready);
    assign cell_ready  = !s1_valid_reg || s1_done;
    assign accept      = cell_valid && cell_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload: bad flag, neighbour flags and cell number within the grid
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bad_reg   <= bad_now;
            s1_down_reg  <= ({1'b0, coord.cell_row} != (rows_sat - GRID_W'(1)));
            s1_right_reg <= ({1'b0, coord.cell_col} != (cols_sat - GRID_W'(1)));
            s1_idx_reg   <= CELL_IDX_W'(cols_sat) * CELL_IDX_W'(coord.cell_row) +
                            CELL_IDX_W'(coord.cell_col);
        end
    end

    // Stage 2: spin offsets, pushed straight into the queue
    always_comb
    begin
        cmd_valid       = s1_valid_reg && push_needed;
        cmd.bad         = s1_bad_reg;
        cmd.base        = SITE_W'(s1_idx_reg) * SITE_W'(two_s);
        cmd.shore       = shore_sat;
        cmd.has_down    = s1_down_reg;
        cmd.has_right   = s1_right_reg;
        cmd.stride_down = SITE_W'(cols_sat) * SITE_W'(two_s);
    end

endmodule

/* sv/cbg_queue.sv */
// Short command queue that decouples the front end from the bond sequencer.
// Depends on cbg_pkg.
module cbg_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cbg_pkg::cbg_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output cbg_pkg::cbg_cmd_t out_cmd
);
    import cbg_pkg::*;

    cbg_cmd_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QDEPTH)
        else $error("queue count above depth");

    // Count tracks the pointer distance
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

/* sv/cbg_back.sv */
// Back end: steps through one cell's bonds, one beat per cycle while the
// output is taken, into an output register. Depends on cbg_pkg; fed by cbg_queue.
module cbg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cbg_pkg::cbg_cfg_t cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cbg_pkg::cbg_cmd_t cmd,
    output logic              bond_valid,
    input  logic              bond_ready,
    output cbg_pkg::cbg_out_t bond
);
    import cbg_pkg::*;

    bk_state_t          state_reg, state_next;
    cbg_cmd_t           cmd_reg;
    logic [SHORE_W-1:0] k_reg, k_next;
    logic [SHORE_W-1:0] l_reg, l_next;
    logic               bond_valid_reg, bond_valid_next;
    cbg_out_t           bond_reg, bond_next;

    logic               advance;
    logic               load;
    logic [SHORE_W-1:0] s_m1;
    logic               k_end, l_end;
    logic [SITE_W-1:0]  base_k;
    logic [SITE_W-1:0]  base_s;
    logic [SITE_W-1:0]  two_s;

    assign advance   = !bond_valid_reg || bond_ready;
    assign cmd_ready = (state_reg == BK_IDLE);
    assign load      = cmd_valid && cmd_ready;

    // Loop bounds and site arithmetic
    always_comb
    begin
        s_m1   = cmd_reg.shore - SHORE_W'(1);
        k_end  = (k_reg == s_m1);
        l_end  = (l_reg == s_m1);
        base_k = cmd_reg.base + SITE_W'(k_reg);
        base_s = cmd_reg.base + SITE_W'(cmd_reg.shore);
        two_s  = SITE_W'({cmd_reg.shore, 1'b0});
    end

    // Sequencer: next state and next beat
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        l_next          = l_reg;
        bond_next       = bond_reg;
        bond_valid_next = bond_valid_reg && !bond_ready;

        bond_next.coupling = cfg.coupling_bits;
        bond_next.bad_cell = 1'b0;
        bond_next.last     = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                bond_next = bond_reg;
                k_next    = '0;
                l_next    = '0;
                if (load)
                begin
                    state_next = cmd.bad ? BK_BAD : BK_INNER;
                end
            end
            BK_BAD:
            begin
                if (advance)
                begin
                    bond_next.site_a   = '0;
                    bond_next.site_b   = '0;
                    bond_next.coupling = '0;
                    bond_next.last     = 1'b1;
                    bond_next.bad_cell = 1'b1;
                    bond_valid_next    = 1'b1;
                    state_next         = BK_IDLE;
                end
                else
                begin
                    bond_next = bond_reg;
                end
            end
            BK_INNER:
            begin
                if (advance)
                begin
                    bond_next.site_a = base_k;
                    bond_next.site_b = base_s + SITE_W'(l_reg);
                    bond_next.last   = k_end && l_end && !cmd_reg.has_down && !cmd_reg.has_right;
                    bond_valid_next  = 1'b1;
                    if (l_end)
                    begin
                        l_next = '0;
                        if (k_end)
                        begin
                            k_next = '0;
                            priority if (cmd_reg.has_down)
                                state_next = BK_DOWN;
                            else if (cmd_reg.has_right)
                                state_next = BK_RIGHT;
                            else
                                state_next = BK_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + SHORE_W'(1);
                        end
                    end
                    else
                    begin
                        l_next = l_reg + SHORE_W'(1);
                    end
                end
                else
                begin
                    bond_next = bond_reg;
                end
            end
            BK_DOWN:
            begin
                if (advance)
                begin
                    bond_next.site_a = base_k;
                    bond_next.site_b = base_k + cmd_reg.stride_down;
                    bond_next.last   = k_end && !cmd_reg.has_right;
                    bond_valid_next  = 1'b1;
                    if (k_end)
                    begin
                        k_next     = '0;
                        state_next = cmd_reg.has_right ? BK_RIGHT : BK_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + SHORE_W'(1);
                    end
                end
                else
                begin
                    bond_next = bond_reg;
                end
            end
            BK_RIGHT:
            begin
                if (advance)
                begin
                    bond_next.site_a = base_s + SITE_W'(k_reg);
                    bond_next.site_b = base_s + SITE_W'(k_reg) + two_s;
                    bond_next.last   = k_end;
                    bond_valid_next  = 1'b1;
                    if (k_end)
                    begin
                        k_next     = '0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + SHORE_W'(1);
                    end
                end
                else
                begin
                    bond_next = bond_reg;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            k_reg          <= '0;
            l_reg          <= '0;
            bond_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            l_reg          <= l_next;
            bond_valid_reg <= bond_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd;
        end
        bond_reg <= bond_next;
    end

    assign bond_valid = bond_valid_reg;
    assign bond       = bond_reg;

    // A bad-cell beat is the only one for its cell and carries zero fields
    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (bond_valid && bond.bad_cell) |->
            (bond.last && bond.site_a == '0 && bond.site_b == '0 && bond.coupling == '0))
        else $error("bad-cell beat malformed");

    // Loop counters stay inside the shore while enumerating
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_INNER || state_reg == BK_DOWN || state_reg == BK_RIGHT) |->
            (k_reg < cmd_reg.shore && l_reg < cmd_reg.shore))
        else $error("bond counter beyond shore size");

    // A good cell never reaches the sequencer with an empty shore
    a_shore_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cmd.bad) |-> (cmd.shore != '0))
        else $error("empty-shore cell reached sequencer");

    // Leaving a bond phase for idle happens only on the beat marked last
    a_last_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE && state_next == BK_IDLE) |=> (bond_valid && bond.last))
        else $error("cell finished without last beat");

endmodule

/* sv/chimera_cell_bond_generator.sv */
// Top level of the Chimera cell bond generator: configuration registers,
// front end, command queue and bond sequencer. Depends on cbg_pkg and all cbg_* modules.
//
// Each accepted cell beat produces that cell's bonds as output beats, one per
// cycle while the output is taken: shore*shore internal bonds, plus shore
// vertical bonds unless the cell sits on the last row, plus shore horizontal
// bonds unless it sits in the last column, with last set on the final beat.
// After a cell's last beat the sequencer returns to idle to load the next
// command; a cell outside the grid yields a single bad_cell beat; a cell
// with shore size zero yields nothing and is dropped by the front end.
// With the sequencer free, an accepted cell is registered in stage 1 of the
// front end, pushed into the queue and loaded by the sequencer, and its
// first beat then goes into the output register. A two-entry queue lets
// the front end accept cells ahead while bonds are still going out.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module chimera_cell_bond_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              cell_valid,
    output logic                              cell_ready,
    input  cbg_pkg::cbg_in_t                  coord,
    output logic                              bond_valid,
    input  logic                              bond_ready,
    output cbg_pkg::cbg_out_t                 bond
);
    import cbg_pkg::*;

    cbg_cfg_t cfg_reg, cfg_next;
    logic     fq_valid, fq_ready;
    cbg_cmd_t fq_cmd;
    logic     qb_valid, qb_ready;
    cbg_cmd_t qb_cmd;

    assign cfg_ready = 1'b1;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_COLS:     cfg_next.grid_cols     = cfg_data[GRID_W-1:0];
                CFG_GRID_ROWS:     cfg_next.grid_rows     = cfg_data[GRID_W-1:0];
                CFG_SHORE_SIZE:    cfg_next.shore_size    = cfg_data[SHORE_W-1:0];
                CFG_COUPLING_BITS: cfg_next.coupling_bits = cfg_data[COUPLING_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_cols     <= GRID_W'(1);
            cfg_reg.grid_rows     <= GRID_W'(1);
            cfg_reg.shore_size    <= SHORE_W'(4);
            cfg_reg.coupling_bits <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .coord      (coord),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    cbg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    cbg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (qb_valid),
        .cmd_ready  (qb_ready),
        .cmd        (qb_cmd),
        .bond_valid (bond_valid),
        .bond_ready (bond_ready),
        .bond       (bond)
    );

endmodule
